[hdl/kne_pkg.sv]
package kne_pkg;

  // decode escape phase
  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_ESC    = 2'd1,
    PH_OCT1   = 2'd2,
    PH_OCT2   = 2'd3
  } phase_t;

  // mode register values
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CASE_BIT      = 8'h20;

  // one queued command: up to four words to emit
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [1:0] cnt_m1;   // number of words minus one
    logic       is_end;   // end-of-string word, no character
    logic       bad;      // status carried on the end word
  } cmd_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic is_oct(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h37);
  endfunction

  // ASCII digit for a 3-bit octal value
  function automatic logic [7:0] oct_char(input logic [2:0] d);
    return {5'b00110, d};
  endfunction

endpackage

[hdl/key_name_escape_codec.sv]
// Key name escape codec. Encode mode (cfg_data 0) maps each key character to
// one to four words: digits pass, lower case goes upper, '.' becomes "__",
// upper case becomes '_' plus the letter, anything else '_' plus three octal
// digits. Decode mode (cfg_data 1) reverses this and flags malformed or
// needless escapes, cut-short escapes and empty names on the end word. An
// input word with in_end_marker set closes the string and yields exactly one
// result with out_last high. The front end takes one input word per cycle
// while the command queue has room; the back end sends one result per cycle while
// out_ready is high and commands wait. A digit or lower-case letter makes one
// result, a dot or upper-case letter two, an octal escape four, and a decode-mode
// input word none or one. Write the mode only while the block is idle.
module key_name_escape_codec #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end_marker,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_last,
  output logic       out_bad_input
);
  import kne_pkg::*;

  logic q_full, q_push, q_pop, q_valid;
  cmd_t q_cmd, q_head;

  kne_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .in_end_marker (in_end_marker),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_cmd)
  );

  kne_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  kne_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (out_last),
    .out_bad_input  (out_bad_input)
  );

endmodule

[hdl/kne_front.sv]
module kne_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          in_end_marker,
  input  logic          q_full,
  output logic          q_push,
  output kne_pkg::cmd_t q_cmd
);
  import kne_pkg::*;

  logic       mode_r;
  phase_t     phase_r, phase_nxt;
  logic [5:0] acc_r, acc_nxt;
  logic       err_r, err_nxt;
  logic       seen_r, seen_nxt;
  logic       accept;
  logic       produce;
  logic [8:0] oct_val;
  logic       oct_ok;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;

  // value of a completed three-digit escape and whether it was needed
  assign oct_val = {acc_r, in_byte[2:0]};
  assign oct_ok  = is_oct(in_byte) && (oct_val != 9'd0) && !oct_val[8] &&
                   !is_digit(oct_val[7:0]) && !is_upper(oct_val[7:0]) &&
                   !is_lower(oct_val[7:0]) && (oct_val[7:0] != CH_DOT);

  // next decode phase
  always_comb begin
    phase_nxt = phase_r;
    if (in_end_marker) begin
      phase_nxt = PH_NORMAL;
    end else if (mode_r == MODE_DECODE && !err_r) begin
      case (phase_r)
        PH_NORMAL: begin
          if (in_byte == CH_UNDERSCORE) phase_nxt = PH_ESC;
        end
        PH_ESC: begin
          if (in_byte == CH_UNDERSCORE || is_upper(in_byte)) phase_nxt = PH_NORMAL;
          else if (is_oct(in_byte)) phase_nxt = PH_OCT1;
        end
        PH_OCT1: begin
          if (is_oct(in_byte)) phase_nxt = PH_OCT2;
        end
        PH_OCT2: begin
          if (oct_ok) phase_nxt = PH_NORMAL;
        end
        default: phase_nxt = PH_NORMAL;
      endcase
    end
  end

  // command words and remaining state
  always_comb begin
    acc_nxt  = acc_r;
    err_nxt  = err_r;
    seen_nxt = 1'b1;
    produce  = 1'b0;
    q_cmd    = '0;
    if (in_end_marker) begin
      produce      = 1'b1;
      q_cmd.is_end = 1'b1;
      q_cmd.bad    = (mode_r == MODE_DECODE) &&
                     (err_r || phase_r != PH_NORMAL || !seen_r);
      acc_nxt      = '0;
      err_nxt      = 1'b0;
      seen_nxt     = 1'b0;
    end else if (mode_r == MODE_ENCODE) begin
      produce = 1'b1;
      if (is_digit(in_byte)) begin
        q_cmd.b0 = in_byte;
      end else if (is_lower(in_byte)) begin
        q_cmd.b0 = in_byte & ~CASE_BIT;
      end else if (in_byte == CH_DOT) begin
        q_cmd.b0     = CH_UNDERSCORE;
        q_cmd.b1     = CH_UNDERSCORE;
        q_cmd.cnt_m1 = 2'd1;
      end else if (is_upper(in_byte)) begin
        q_cmd.b0     = CH_UNDERSCORE;
        q_cmd.b1     = in_byte;
        q_cmd.cnt_m1 = 2'd1;
      end else begin
        q_cmd.b0     = CH_UNDERSCORE;
        q_cmd.b1     = oct_char({1'b0, in_byte[7:6]});
        q_cmd.b2     = oct_char(in_byte[5:3]);
        q_cmd.b3     = oct_char(in_byte[2:0]);
        q_cmd.cnt_m1 = 2'd3;
      end
    end else if (!err_r) begin
      case (phase_r)
        PH_NORMAL: begin
          if (is_digit(in_byte)) begin
            produce  = 1'b1;
            q_cmd.b0 = in_byte;
          end else if (is_upper(in_byte)) begin
            produce  = 1'b1;
            q_cmd.b0 = in_byte | CASE_BIT;
          end else if (in_byte != CH_UNDERSCORE) begin
            err_nxt = 1'b1;
          end
        end
        PH_ESC: begin
          if (in_byte == CH_UNDERSCORE) begin
            produce  = 1'b1;
            q_cmd.b0 = CH_DOT;
          end else if (is_upper(in_byte)) begin
            produce  = 1'b1;
            q_cmd.b0 = in_byte;
          end else if (is_oct(in_byte)) begin
            acc_nxt = {3'd0, in_byte[2:0]};
          end else begin
            err_nxt = 1'b1;
          end
        end
        PH_OCT1: begin
          if (is_oct(in_byte)) acc_nxt = {acc_r[2:0], in_byte[2:0]};
          else err_nxt = 1'b1;
        end
        PH_OCT2: begin
          if (oct_ok) begin
            produce  = 1'b1;
            q_cmd.b0 = oct_val[7:0];
            acc_nxt  = '0;
          end else begin
            err_nxt = 1'b1;
          end
        end
        default: err_nxt = 1'b1;
      endcase
    end
  end

  assign q_push = accept && produce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_ENCODE;
      phase_r <= PH_NORMAL;
      acc_r   <= '0;
      err_r   <= 1'b0;
      seen_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) mode_r <= cfg_data;
      if (accept) begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        err_r   <= err_nxt;
        seen_r  <= seen_nxt;
      end
    end
  end

endmodule

[hdl/kne_queue.sv]
module kne_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  kne_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output kne_pkg::cmd_t head
);
  import kne_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  cmd_t          slots_r [DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == DEPTH_C);
  assign valid   = (cnt_r != '0);
  assign head    = slots_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_r <= (wr_r == LAST_PTR) ? '0 : wr_r + 1'b1;
      if (do_pop)  rd_r <= (rd_r == LAST_PTR) ? '0 : rd_r + 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) slots_r[wr_r] <= push_cmd;
  end

endmodule

[hdl/kne_back.sv]
module kne_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  kne_pkg::cmd_t q_head,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_byte_valid,
  output logic          out_last,
  output logic          out_bad_input
);
  import kne_pkg::*;

  cmd_t       hold_r;
  logic       hold_v_r;
  logic [1:0] idx_r;
  logic       out_v_r;
  logic [7:0] byte_r;
  logic       bv_r, last_r, bad_r;
  logic       adv;
  logic       fin;
  logic [7:0] sel_byte;

  assign adv   = !out_v_r || out_ready;
  assign fin   = hold_v_r && adv && (idx_r == hold_r.cnt_m1);
  assign q_pop = q_valid && (!hold_v_r || fin);

  // word picked from the held command
  always_comb begin
    case (idx_r)
      2'd0:    sel_byte = hold_r.b0;
      2'd1:    sel_byte = hold_r.b1;
      2'd2:    sel_byte = hold_r.b2;
      2'd3:    sel_byte = hold_r.b3;
      default: sel_byte = hold_r.b0;
    endcase
  end

  // held command and word index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      idx_r    <= '0;
    end else if (q_pop) begin
      hold_v_r <= 1'b1;
      idx_r    <= '0;
    end else if (fin) begin
      hold_v_r <= 1'b0;
    end else if (hold_v_r && adv) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) hold_r <= q_head;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= hold_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && hold_v_r) begin
      byte_r <= hold_r.is_end ? 8'd0 : sel_byte;
      bv_r   <= !hold_r.is_end;
      last_r <= hold_r.is_end;
      bad_r  <= hold_r.is_end && hold_r.bad;
    end
  end

  assign out_valid      = out_v_r;
  assign out_byte       = byte_r;
  assign out_byte_valid = bv_r;
  assign out_last       = last_r;
  assign out_bad_input  = bad_r;

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
  import kne_pkg::*;

  localparam int ITEM_TARGET     = 500;
  localparam int PHASE_ITEMS     = 60;
  localparam int SETTLE_CYCLES   = 16;
  localparam int PRESSURE_CYCLES = 150;
  localparam int CYCLE_LIMIT     = 300000;
  localparam int MAX_REPORTS     = 30;

  // one result word as the block emits it
  typedef struct packed {
    logic [7:0] ch;
    logic       has_ch;
    logic       lst;
    logic       bad;
  } key_word_t;

  // escape sequence for one key character: up to four words
  typedef struct packed {
    logic [2:0]      cnt;
    logic [0:3][7:0] seq;
  } esc_seq_t;

  typedef enum logic [2:0] {
    CK_DIGIT,
    CK_UPPER,
    CK_LOWER,
    CK_DOT,
    CK_UNDER,
    CK_OTHER
  } char_kind_t;

  // Predicts the result words of the codec and checks them in order.
  class escape_scoreboard;
    logic       mode;
    phase_t     phase;
    logic [8:0] oct_acc;
    bit         err_flag;
    bit         got_char;
    key_word_t  want_q[$];
    int         n_errors;
    int         n_checked;
    int         n_ends;
    int         n_bad_ends;

    function new();
      mode       = MODE_ENCODE;
      n_errors   = 0;
      n_checked  = 0;
      n_ends     = 0;
      n_bad_ends = 0;
      clear_name();
    endfunction

    function void clear_name();
      phase    = PH_NORMAL;
      oct_acc  = '0;
      err_flag = 1'b0;
      got_char = 1'b0;
    endfunction

    function char_kind_t kind_of(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return CK_DIGIT;
      if (c >= 8'h41 && c <= 8'h5A) return CK_UPPER;
      if (c >= 8'h61 && c <= 8'h7A) return CK_LOWER;
      if (c == CH_DOT) return CK_DOT;
      if (c == CH_UNDERSCORE) return CK_UNDER;
      return CK_OTHER;
    endfunction

    // what the encoder makes of one key character
    function esc_seq_t escape_seq(logic [7:0] c);
      esc_seq_t s;
      s = '0;
      case (kind_of(c))
        CK_DIGIT: begin
          s.cnt    = 3'd1;
          s.seq[0] = c;
        end
        CK_LOWER: begin
          s.cnt    = 3'd1;
          s.seq[0] = c & ~CASE_BIT;
        end
        CK_DOT: begin
          s.cnt    = 3'd2;
          s.seq[0] = CH_UNDERSCORE;
          s.seq[1] = CH_UNDERSCORE;
        end
        CK_UPPER: begin
          s.cnt    = 3'd2;
          s.seq[0] = CH_UNDERSCORE;
          s.seq[1] = c;
        end
        default: begin
          // three octal digits of the unsigned value
          s.cnt    = 3'd4;
          s.seq[0] = CH_UNDERSCORE;
          s.seq[1] = CH_ZERO | {6'b0, c[7:6]};
          s.seq[2] = CH_ZERO | {5'b0, c[5:3]};
          s.seq[3] = CH_ZERO | {5'b0, c[2:0]};
        end
      endcase
      return s;
    endfunction

    function void expect_char(logic [7:0] c);
      key_word_t w;
      w        = '0;
      w.ch     = c;
      w.has_ch = 1'b1;
      want_q.push_back(w);
    endfunction

    // escape state machine of the decoder
    function void decode_char(logic [7:0] c);
      char_kind_t k;
      bit         octd;
      logic [8:0] v;
      k    = kind_of(c);
      octd = (c >= 8'h30) && (c <= 8'h37);
      case (phase)
        PH_NORMAL: begin
          if (k == CK_DIGIT) expect_char(c);
          else if (k == CK_UPPER) expect_char(c | CASE_BIT);
          else if (k == CK_UNDER) phase = PH_ESC;
          else err_flag = 1'b1;
        end
        PH_ESC: begin
          if (k == CK_UNDER) begin
            expect_char(CH_DOT);
            phase = PH_NORMAL;
          end else if (k == CK_UPPER) begin
            expect_char(c);
            phase = PH_NORMAL;
          end else if (octd) begin
            oct_acc = {6'b0, c[2:0]};
            phase   = PH_OCT1;
          end else begin
            err_flag = 1'b1;
          end
        end
        PH_OCT1: begin
          if (octd) begin
            oct_acc = {oct_acc[5:0], c[2:0]};
            phase   = PH_OCT2;
          end else begin
            err_flag = 1'b1;
          end
        end
        default: begin
          v = {oct_acc[5:0], c[2:0]};
          // zero, out of byte range, or a char that needs no escape
          if (!octd || v == 9'd0 || v[8] ||
              (kind_of(v[7:0]) != CK_UNDER && kind_of(v[7:0]) != CK_OTHER)) begin
            err_flag = 1'b1;
          end else begin
            expect_char(v[7:0]);
            phase   = PH_NORMAL;
            oct_acc = '0;
          end
        end
      endcase
    endfunction

    // note an accepted input word; returns 0 when the block just drops it
    function bit note_input(logic [7:0] c, logic e);
      key_word_t w;
      esc_seq_t  s;
      if (e) begin
        w     = '0;
        w.lst = 1'b1;
        w.bad = (mode == MODE_DECODE) && (err_flag || phase != PH_NORMAL || !got_char);
        want_q.push_back(w);
        n_ends++;
        if (w.bad) n_bad_ends++;
        clear_name();
        return 1'b1;
      end
      got_char = 1'b1;
      if (mode == MODE_ENCODE) begin
        s = escape_seq(c);
        for (int i = 0; i < s.cnt; i++) expect_char(s.seq[i]);
        return 1'b1;
      end
      if (err_flag) return 1'b0;
      decode_char(c);
      return 1'b1;
    endfunction

    task flag_mismatch(string msg);
      n_errors++;
      if (n_errors <= MAX_REPORTS) $display("MISMATCH: %s", msg);
    endtask

    // compare one accepted result word with the oldest expectation
    task check_word(logic [7:0] b, logic bv, logic l, logic bad);
      key_word_t w;
      if (want_q.size() == 0) begin
        flag_mismatch($sformatf("word with nothing expected: byte=%02h valid=%0b last=%0b bad=%0b",
                                b, bv, l, bad));
        return;
      end
      w = want_q.pop_front();
      n_checked++;
      if (b !== w.ch)
        flag_mismatch($sformatf("word %0d out_byte %02h, want %02h", n_checked, b, w.ch));
      if (bv !== w.has_ch)
        flag_mismatch($sformatf("word %0d out_byte_valid %0b, want %0b", n_checked, bv, w.has_ch));
      if (l !== w.lst)
        flag_mismatch($sformatf("word %0d out_last %0b, want %0b", n_checked, l, w.lst));
      if (bad !== w.bad)
        flag_mismatch($sformatf("word %0d out_bad_input %0b, want %0b", n_checked, bad, w.bad));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_end_marker = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_last;
  logic       out_bad_input;

  escape_scoreboard sb;

  bit calm = 1'b0;
  bit pressure_go = 1'b0;
  bit pressure_done = 1'b0;
  bit rx_took = 1'b0;
  int rx_gap = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int n_items = 0;
  int n_effective = 0;
  int n_cfg_writes = 0;

  key_name_escape_codec dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .in_end_marker (in_end_marker),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_byte_valid(out_byte_valid),
    .out_last      (out_last),
    .out_bad_input (out_bad_input)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_word(out_byte, out_byte_valid, out_last, out_bad_input);
      rx_took = 1'b1;
    end
  end

  // receiver: random stall per word, plus one long hold-off
  always @(negedge clk) begin
    if (rx_took) begin
      rx_took = 1'b0;
      rx_gap  = calm ? 0 : $urandom_range(0, 9);
    end
    if (pressure_go && !pressure_done) begin
      pressure_done = 1'b1;
      hold_left     = PRESSURE_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("key_name_escape_codec test failed");
    $finish;
  end

  function automatic logic [7:0] pick_key_char(bit allow_zero);
    case ($urandom_range(0, 9))
      0, 1:    return 8'h30 + 8'($urandom_range(0, 9));
      2, 3:    return 8'h61 + 8'($urandom_range(0, 25));
      4, 5:    return 8'h41 + 8'($urandom_range(0, 25));
      6:       return CH_DOT;
      7:       return CH_UNDERSCORE;
      default: return 8'($urandom_range(allow_zero ? 0 : 1, 255));
    endcase
  endfunction

  // offer one input word after a random gap and wait for it to go in
  task send_item(logic [7:0] b, logic e);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_byte       <= b;
    in_end_marker <= e;
    do @(posedge clk); while (!in_ready);
    n_items++;
    n_effective += sb.note_input(b, e);
  endtask

  task send_str(string s, bit close);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    if (close) send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task write_mode(logic m);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    sb.mode = m;
    n_cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until every expected word is in and the block has gone quiet
  task settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.want_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task send_key_string();
    int n;
    n = $urandom_range(0, 8);
    repeat (n) begin
      if ($urandom_range(0, 9) < 4) send_item(8'($urandom_range(0, 255)), 1'b0);
      else send_item(pick_key_char(1'b1), 1'b0);
    end
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // mostly well-formed encoded names, some broken, some empty, some noise
  task send_decode_name();
    logic [7:0] enc[$];
    esc_seq_t   es;
    logic [8:0] v;
    int         pick;
    int         n;
    int         pos;
    pick = $urandom_range(0, 99);
    if (pick >= 95) begin
      n = $urandom_range(1, 6);
      repeat (n) enc.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 90) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        es = sb.escape_seq(pick_key_char(1'b0));
        for (int i = 0; i < es.cnt; i++) enc.push_back(es.seq[i]);
      end
      if (pick >= 70 && pick < 78) begin
        // one word overwritten
        pos      = $urandom_range(0, enc.size() - 1);
        enc[pos] = 8'($urandom_range(0, 255));
      end else if (pick >= 78 && pick < 84) begin
        // octal escape that is zero, too large or needless
        case ($urandom_range(0, 3))
          0:       v = 9'd0;
          1:       v = 9'($urandom_range(256, 511));
          2:       v = {1'b0, pick_key_char(1'b0)};
          default: v = 9'($urandom_range(0, 511));
        endcase
        enc.push_back(CH_UNDERSCORE);
        enc.push_back(CH_ZERO | {5'b0, v[8:6]});
        enc.push_back(CH_ZERO | {5'b0, v[5:3]});
        enc.push_back(CH_ZERO | {5'b0, v[2:0]});
      end else if (pick >= 84) begin
        // name cut short, often inside an escape
        repeat ($urandom_range(1, 2)) if (enc.size() > 1) void'(enc.pop_back());
      end
    end
    foreach (enc[i]) send_item(enc[i], 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    int ph;
    int phase_start;
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // encode under the reset mode: each character class and byte extremes
    send_str("0zA.", 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h5A, 1'b1);
    settle();

    // decode: good name, empty name, escape cut short, zero byte
    write_mode(MODE_DECODE);
    send_str("9A___Z_377", 1'b1);
    send_item(8'h00, 1'b1);
    send_str("_1", 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    settle();

    // random phases alternating the mode
    for (ph = 0; ph < 4 || n_effective < ITEM_TARGET; ph++) begin
      calm = (ph % 4 == 3);
      write_mode((ph % 2 == 1) ? MODE_DECODE : MODE_ENCODE);
      if (ph == 2) pressure_go = 1'b1;
      phase_start = n_effective;
      while (n_effective - phase_start < PHASE_ITEMS) begin
        if (sb.mode == MODE_DECODE) send_decode_name();
        else send_key_string();
      end
      // sometimes leave a name open across the mode change
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) send_item(pick_key_char(1'b1), 1'b0);
      settle();
    end

    $display("Sent %0d input words in %0d names over %0d mode writes, idle gaps on both sides",
             n_items, sb.n_ends, n_cfg_writes);
    $display("and one long output hold-off; %0d result words checked, %0d names flagged bad.",
             sb.n_checked, sb.n_bad_ends);
    if (sb.n_errors == 0 && sb.want_q.size() == 0) begin
      $display("key_name_escape_codec test passed");
    end else begin
      $display("key_name_escape_codec test failed");
    end
    $finish;
  end

endmodule
